[hw/rtl/masr_pkg.sv]
// masr_pkg: shared types and constants for the max absolute simple return core
// command and status structs between controller and datapath
// no dependencies
`default_nettype none

package masr_pkg;

    localparam int RET_WIDTH = 32;

    typedef struct packed {
        logic load;
        logic step;
        logic update;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pair;
        logic div_done;
        logic item_end;
    } t_status;

endpackage

`default_nettype wire

[hw/rtl/masr_datapath.sv]
// masr_datapath: series state, bit-serial restoring divider and result register
// depends on masr_pkg (t_cmd, t_status, RET_WIDTH)
`default_nettype none

module masr_datapath #(
    parameter int PRICE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire masr_pkg::t_cmd           i_cmd,
    output masr_pkg::t_status             o_status,
    input  wire signed [PRICE_WIDTH-1:0]  i_price,
    input  wire                           i_price_missing,
    input  wire                           i_series_start,
    input  wire                           i_series_end,
    output logic [masr_pkg::RET_WIDTH-1:0] o_max_abs_return,
    output logic                          o_has_value
);

    localparam int RW = masr_pkg::RET_WIDTH;
    localparam int NW = PRICE_WIDTH + FRACTION_BITS;
    localparam int CW = $clog2(NW);
    localparam int QW = (NW > RW) ? NW : RW + 1;

    logic [PRICE_WIDTH-1:0] r_prev_price;
    logic                   r_prev_usable;
    logic [RW-1:0]          r_best;
    logic                   r_best_present;
    logic                   r_end;
    logic [PRICE_WIDTH-1:0] r_div;
    logic [PRICE_WIDTH-1:0] r_rem;
    logic [NW-1:0]          r_num;
    logic [NW-1:0]          r_quot;
    logic [CW-1:0]          r_cnt;

    logic                   usable;
    logic                   prev_usable_eff;
    logic [PRICE_WIDTH-1:0] price_u;
    logic [PRICE_WIDTH-1:0] diff;
    logic [PRICE_WIDTH-1:0] rem_sh;
    logic                   q_bit;
    logic [QW-1:0]          quot_ext;
    logic [RW-1:0]          q_sat;

    assign price_u         = PRICE_WIDTH'(i_price);
    assign usable          = !i_price_missing && (price_u != '0) && !price_u[PRICE_WIDTH-1];
    assign prev_usable_eff = r_prev_usable && !i_series_start;
    assign diff            = (price_u >= r_prev_price) ? (price_u - r_prev_price)
                                                       : (r_prev_price - price_u);

    // remainder stays below the divisor, so the shifted value fits
    assign rem_sh   = {r_rem[PRICE_WIDTH-2:0], r_num[NW-1]};
    assign q_bit    = (rem_sh >= r_div);
    assign quot_ext = QW'(r_quot);
    assign q_sat    = (|quot_ext[QW-1:RW]) ? {RW{1'b1}} : quot_ext[RW-1:0];

    assign o_status.pair     = usable && prev_usable_eff;
    assign o_status.div_done = (r_cnt == CW'(NW - 1));
    assign o_status.item_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_price   <= '0;
            r_prev_usable  <= 1'b0;
            r_best         <= '0;
            r_best_present <= 1'b0;
            r_end          <= 1'b0;
            r_cnt          <= '0;
        end else begin
            if (i_cmd.load) begin
                if (i_series_start) begin
                    r_best         <= '0;
                    r_best_present <= 1'b0;
                end
                r_div         <= r_prev_price;
                r_num         <= {diff, {FRACTION_BITS{1'b0}}};
                r_rem         <= '0;
                r_quot        <= '0;
                r_cnt         <= '0;
                r_end         <= i_series_end;
                r_prev_price  <= price_u;
                r_prev_usable <= usable;
            end
            if (i_cmd.step) begin
                r_rem  <= q_bit ? (rem_sh - r_div) : rem_sh;
                r_num  <= {r_num[NW-2:0], 1'b0};
                r_quot <= {r_quot[NW-2:0], q_bit};
                r_cnt  <= r_cnt + CW'(1);
            end
            if (i_cmd.update) begin
                if (!r_best_present || (q_sat > r_best)) begin
                    r_best         <= q_sat;
                    r_best_present <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_prev_price   <= '0;
                r_prev_usable  <= 1'b0;
                r_best         <= '0;
                r_best_present <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_max_abs_return <= r_best_present ? r_best : '0;
            o_has_value      <= r_best_present;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/masr_controller.sv]
// masr_controller: sequencer for accept, divide, update and emit
// depends on masr_pkg (t_cmd, t_status)
`default_nettype none

module masr_controller (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire masr_pkg::t_status i_status,
    output masr_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_UPD  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;
    // update only after a division ran
    logic   r_did_div;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.update = 1'b0;
        o_cmd.emit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_status.pair) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // without a pair no update is issued; this state then only routes an end mark
                o_cmd.update = r_did_div;
                n_state      = i_status.item_end ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_did_div   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) begin
                r_did_div <= 1'b1;
            end else if (r_state == S_UPD) begin
                r_did_div <= 1'b0;
            end
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/max_abs_simple_return_core.sv]
// max_abs_simple_return_core: top level, joins controller and datapath
// depends on masr_pkg, masr_controller, masr_datapath
//
// One price sample is taken per request. A sample that forms a usable pair with
// the one before it runs a bit-serial restoring divider, one quotient bit per
// cycle, through the idle (load), divide and update states; any other item
// passes the idle (load) and update states only. A series end adds an emit
// state that loads the result register, which then waits for the output request
// to be taken while the next sample is already accepted. No clearing pass.
`default_nettype none

module max_abs_simple_return_core #(
    parameter int PRICE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire signed [PRICE_WIDTH-1:0]  i_price,
    input  wire                           i_price_missing,
    input  wire                           i_series_start,
    input  wire                           i_series_end,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [masr_pkg::RET_WIDTH-1:0] o_max_abs_return,
    output logic                          o_has_value
);

    masr_pkg::t_cmd    cmd;
    masr_pkg::t_status status;

    masr_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    masr_datapath #(
        .PRICE_WIDTH   (PRICE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_price          (i_price),
        .i_price_missing  (i_price_missing),
        .i_series_start   (i_series_start),
        .i_series_end     (i_series_end),
        .o_max_abs_return (o_max_abs_return),
        .o_has_value      (o_has_value)
    );

endmodule

`default_nettype wire
